/* hdl/stbs_pkg.sv */
package stbs_pkg;

  localparam int LABEL_W = 32;
  localparam int POS_W   = 11;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINISH
  } state_t;

endpackage

/* hdl/stbs_ram.sv */
module stbs_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic        [ADDR_W-1:0]             wr_addr,
  input  logic signed [stbs_pkg::LABEL_W-1:0]  wr_data,
  input  logic                                 rd_en,
  input  logic        [ADDR_W-1:0]             rd_addr,
  output logic signed [stbs_pkg::LABEL_W-1:0]  rd_data
);
  import stbs_pkg::*;

  logic signed [LABEL_W-1:0] mem [DEPTH];
  logic signed [LABEL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/sorted_table_binary_search.sv */
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | in_mode, in_label_value
// out_     | output    | out_valid/out_stall| out_found, out_position, out_overflow
//
// clear, append and unused mode load the result word at accept
// lookup makes P probes, at most ceil(log2(TABLE_DEPTH+1)),
// one probe per cycle through the single read port of the label memory
// rst_n (synchronous) empties the table; memory contents are not cleared
// out_stall holds the result register; a new word is taken only once it can drain
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [stbs_pkg::MODE_W-1:0]   in_mode,
  input  logic signed [stbs_pkg::LABEL_W-1:0]  in_label_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic        [stbs_pkg::POS_W-1:0]    out_position,
  output logic                                 out_overflow
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int BW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  function automatic logic [POS_W-1:0] to_pos(input logic [CW-1:0] v);
    logic [CW+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, v};
    return ext[POS_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic signed [LABEL_W-1:0] key_r, key_nxt;
  logic [BW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic res_found_r, res_found_nxt;
  logic [CW-1:0] res_pos_r, res_pos_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_position_r, out_position_nxt;
  logic out_overflow_r, out_overflow_nxt;

  logic slot_free, accept;
  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [LABEL_W-1:0] rd_data;
  logic probe_eq, probe_lt;
  logic [BW-1:0] count_ext, smid, mid_m1, nlo, nhi, pmid;
  logic [BW:0] psum;

  stbs_ram #(
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_label_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;

  // probe arithmetic: bounds are 1-based, entry mid-1 is read
  assign count_ext = {1'b0, count_r};
  assign smid      = (BW'(1) + count_ext) >> 1;
  assign probe_eq  = (rd_data == key_r);
  assign probe_lt  = (key_r < rd_data);
  assign mid_m1    = mid_r - BW'(1);
  assign nlo       = probe_lt ? lo_r : (mid_r + BW'(1));
  assign nhi       = probe_lt ? mid_m1 : hi_r;
  assign psum      = {1'b0, nlo} + {1'b0, nhi};
  assign pmid      = psum[BW:1];
  assign wr_addr   = count_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r          <= key_nxt;
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    mid_r          <= mid_nxt;
    res_found_r    <= res_found_nxt;
    res_pos_r      <= res_pos_nxt;
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    key_nxt          = key_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    mid_nxt          = mid_r;
    res_found_nxt    = res_found_r;
    res_pos_nxt      = res_pos_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    out_overflow_nxt = out_overflow_r;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_found_nxt    = 1'b0;
          out_position_nxt = '0;
          out_overflow_nxt = 1'b0;
          case (in_mode)
            MODE_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            MODE_APPEND: begin
              out_valid_nxt    = 1'b1;
              out_position_nxt = to_pos(count_r);
              if (count_r >= DEPTH_C) begin
                out_overflow_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_LOOKUP: begin
              key_nxt = in_label_value;
              lo_nxt  = BW'(1);
              hi_nxt  = count_ext;
              if (count_r == '0) begin
                res_found_nxt = 1'b0;
                res_pos_nxt   = '0;
                state_nxt     = ST_FINISH;
              end else begin
                mid_nxt   = smid;
                rd_en     = 1'b1;
                rd_addr   = AW'(smid - BW'(1));
                state_nxt = ST_PROBE;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (probe_eq) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = CW'(mid_m1);
          state_nxt     = ST_FINISH;
        end else if (nlo > nhi) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = CW'(nhi);
          state_nxt     = ST_FINISH;
        end else begin
          lo_nxt  = nlo;
          hi_nxt  = nhi;
          mid_nxt = pmid;
          rd_en   = 1'b1;
          rd_addr = AW'(pmid - BW'(1));
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = res_found_r;
          out_position_nxt = to_pos(res_pos_r);
          out_overflow_nxt = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_overflow = out_overflow_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above table depth");

  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (lo_r <= mid_r) && (mid_r <= hi_r) && (hi_r <= count_ext))
    else $error("probe index outside search bounds");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_LOOKUP)) |=> (state_r != ST_IDLE))
    else $error("lookup produced no search");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_found_r && out_overflow_r))
    else $error("found and overflow both set");

endmodule

/* tb/tb_sorted_table_binary_search.sv */
`timescale 1ns / 100ps

module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam logic signed [LABEL_W-1:0] LABEL_MIN = 32'sh8000_0000;
  localparam logic signed [LABEL_W-1:0] LABEL_MAX = 32'sh7fff_ffff;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;
  } search_word_t;

  // tracks the label table and the words the block still owes
  class label_table_tracker;
    logic signed [LABEL_W-1:0] labels [TABLE_DEPTH];
    int unsigned stored;
    search_word_t expected_words [$];
    int errors;

    function new();
      stored = 0;
      errors = 0;
    endfunction

    function search_word_t search_table(logic signed [LABEL_W-1:0] key);
      search_word_t w;
      int unsigned lo, hi, mid;
      logic signed [LABEL_W-1:0] probe;
      w = '0;
      lo = 1;
      hi = stored;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        probe = labels[mid - 1];
        if (probe == key) begin
          w.found = 1'b1;
          w.position = POS_W'(mid - 1);
          return w;
        end
        if (key < probe) hi = mid - 1;
        else lo = mid + 1;
      end
      w.position = POS_W'(hi);
      return w;
    endfunction

    function void note_word(logic [MODE_W-1:0] mode, logic signed [LABEL_W-1:0] value);
      search_word_t w;
      w = '0;
      case (mode)
        MODE_CLEAR: begin
          stored = 0;
        end
        MODE_APPEND: begin
          w.position = POS_W'(stored);
          if (stored >= TABLE_DEPTH) begin
            w.overflow = 1'b1;
          end else begin
            labels[stored] = value;
            stored++;
          end
        end
        MODE_LOOKUP: begin
          w = search_table(value);
        end
        default: ;
      endcase
      expected_words.push_back(w);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    endtask

    task check_word(logic found, logic [POS_W-1:0] position, logic overflow);
      search_word_t w;
      if (expected_words.size() == 0) begin
        report("unexpected word", {found, position, overflow}, 0);
      end else begin
        w = expected_words.pop_front();
        if (found !== w.found) report("found", found, w.found);
        if (position !== w.position) report("position", position, w.position);
        if (overflow !== w.overflow) report("overflow", overflow, w.overflow);
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [MODE_W-1:0]         in_mode = MODE_CLEAR;
  logic signed [LABEL_W-1:0] in_label_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_found;
  logic [POS_W-1:0]          out_position;
  logic                      out_overflow;

  label_table_tracker sb;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_req = 1'b0;
  int items_sent = 0;

  sorted_table_binary_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_label_value(in_label_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_found(out_found),
    .out_position(out_position),
    .out_overflow(out_overflow)
  );

  always #5 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_word(out_found, out_position, out_overflow);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic [MODE_W-1:0] mode, logic signed [LABEL_W-1:0] value);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_label_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(mode, value);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic signed [LABEL_W-1:0] pick_key();
    int r;
    logic signed [LABEL_W-1:0] k;
    r = $urandom_range(0, 99);
    if (sb.stored > 0 && r < 40) begin
      k = sb.labels[$urandom_range(0, sb.stored - 1)];
    end else if (sb.stored > 0 && r < 60) begin
      k = sb.labels[$urandom_range(0, sb.stored - 1)];
      k = $urandom_range(0, 1) ? k + 1 : k - 1;
    end else if (r < 70) begin
      k = $urandom_range(0, 1) ? LABEL_MIN : LABEL_MAX;
    end else begin
      k = $urandom();
    end
    return k;
  endfunction

  // clear, then n ascending labels; a small step gives duplicates
  task automatic load_sorted(int n, int unsigned max_step);
    longint cur;
    logic signed [LABEL_W-1:0] v;
    v = $urandom();
    send_word(MODE_CLEAR, v);
    if ($urandom_range(0, 4) == 0) cur = LABEL_MIN;
    else cur = longint'(v);
    for (int i = 0; i < n; i++) begin
      if (i > 0) cur += longint'($urandom_range(0, max_step));
      if (cur > longint'(LABEL_MAX)) cur = LABEL_MAX;
      v = cur[31:0];
      send_word(MODE_APPEND, v);
    end
  endtask

  task automatic run_sequences(int budget);
    int first, r, n;
    int unsigned step;
    first = items_sent;
    while (items_sent - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 24);
        if (n > budget) n = budget;
        case ($urandom_range(0, 3))
          0: step = 3;
          1: step = 1000;
          2: step = 1 << 20;
          default: step = 32'hffff_ffff / (n + 1);
        endcase
        load_sorted(n, step);
        repeat ($urandom_range(1, 20)) send_word(MODE_LOOKUP, pick_key());
      end else if (r < 85) begin
        // out-of-order appends on top of whatever is stored
        repeat ($urandom_range(1, 6)) send_word(MODE_APPEND, $urandom());
        repeat ($urandom_range(1, 8)) send_word(MODE_LOOKUP, pick_key());
      end else begin
        send_word($urandom_range(0, 1) ? MODE_NOP : MODE_LOOKUP, $urandom());
      end
    end
  endtask

  task automatic fill_table();
    load_sorted(TABLE_DEPTH, $urandom_range(1 << 18, 1 << 23));
    send_word(MODE_APPEND, LABEL_MAX);
    send_word(MODE_APPEND, $urandom());
    send_word(MODE_LOOKUP, LABEL_MAX);
    send_word(MODE_LOOKUP, LABEL_MIN);
    repeat (20) send_word(MODE_LOOKUP, pick_key());
  endtask

  initial begin
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct = 38;
    out_idle_pct = 46;
    // empty table, extremes, duplicates, unused mode, clear
    send_word(MODE_LOOKUP, 32'sd0);
    send_word(MODE_LOOKUP, LABEL_MIN);
    send_word(MODE_APPEND, LABEL_MIN);
    send_word(MODE_APPEND, -32'sd1);
    send_word(MODE_APPEND, 32'sd0);
    send_word(MODE_APPEND, 32'sd1);
    send_word(MODE_APPEND, 32'sd1);
    send_word(MODE_APPEND, LABEL_MAX);
    send_word(MODE_LOOKUP, LABEL_MIN);
    send_word(MODE_LOOKUP, LABEL_MAX);
    send_word(MODE_LOOKUP, 32'sd0);
    send_word(MODE_LOOKUP, 32'sd1);
    send_word(MODE_LOOKUP, -32'sd2);
    send_word(MODE_LOOKUP, 32'sd2);
    send_word(MODE_LOOKUP, LABEL_MIN + 1);
    send_word(MODE_NOP, 32'shffff_ffff);
    send_word(MODE_NOP, 32'sd0);
    send_word(MODE_CLEAR, 32'shaaaa_aaaa);
    send_word(MODE_LOOKUP, 32'sd5);
    send_word(MODE_APPEND, 32'sd42);
    send_word(MODE_LOOKUP, 32'sd42);
    send_word(MODE_LOOKUP, 32'sd43);
    send_word(MODE_LOOKUP, 32'sd41);
    run_sequences(15);
    drain();

    in_idle_pct = 46;
    out_idle_pct = 38;
    run_sequences(15);
    drain();

    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_req = 1'b1;
    fill_table();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
